// ----- sv/reader_response_frame_checker_unit_assert.svh -----
// assertion macros for the frame checker
`ifndef READER_RESPONSE_FRAME_CHECKER_UNIT_ASSERT_SVH
`define READER_RESPONSE_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define RRFC_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRFC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rrfc_pkg.sv -----
package rrfc_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 9;
	localparam int OUT_W  = 112;

	localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
	localparam logic [7:0]  OPCODE_TAG_READ = 8'h22;
	localparam logic [7:0]  LEN_UNKNOWN_REC = 8'h08;
	localparam logic [15:0] STATUS_KEEPALIVE = 16'h0400;
	localparam logic [15:0] STATUS_THROTTLE  = 16'h0504;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;

	localparam logic [2:0] KIND_TAG       = 3'd0;
	localparam logic [2:0] KIND_KEEPALIVE = 3'd1;
	localparam logic [2:0] KIND_THROTTLE  = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
	localparam logic [2:0] KIND_BAD_CRC   = 3'd4;
	localparam logic [2:0] KIND_BAD_OP    = 3'd5;

	typedef struct packed {
		logic [31:0] timestamp_ms;
		logic [23:0] frequency_khz;
		logic [7:0]  antenna_ports;
		logic signed [7:0] signal_strength;
		logic [7:0]  data_length;
		logic [15:0] frame_status;
		logic [7:0]  frame_opcode;
		logic [2:0]  frame_kind;
	} result_t;

endpackage

// ----- sv/rrfc_crc.sv -----
module rrfc_crc
	import rrfc_pkg::*;
(
	input  logic [15:0]       crc_cur,
	input  logic [BYTE_W-1:0] data,
	output logic [15:0]       crc_next
);

	localparam logic [15:0] NIB_TABLE [16] = '{
		16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
		16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
	};

	logic [15:0] crc_mid;

	// high nibble first, then low nibble
	assign crc_mid  = {crc_cur[11:0], data[7:4]} ^ NIB_TABLE[crc_cur[15:12]];
	assign crc_next = {crc_mid[11:0], data[3:0]} ^ NIB_TABLE[crc_mid[15:12]];

endmodule

// ----- sv/rrfc_parser.sv -----
module rrfc_parser
	import rrfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data,
	output logic              fire,
	output result_t           res
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  op_q, op_d;
	logic [15:0] status_q, status_d;
	logic [15:0] crc_q, crc_d, crc_upd;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [7:0]  rssi_q, rssi_d;
	logic [7:0]  ant_q, ant_d;
	logic [23:0] freq_q, freq_d;
	logic [31:0] ts_q, ts_d;

	logic [POS_W-1:0] body_end;
	logic [POS_W-1:0] crc_hi_pos;
	logic             in_body;
	logic             in_payload;
	logic [2:0]       kind;
	logic             tag;

	rrfc_crc u_crc (
		.crc_cur  (crc_q),
		.data     (data),
		.crc_next (crc_upd)
	);

	assign body_end   = {1'b0, len_q} + POS_W'(4);
	assign crc_hi_pos = {1'b0, len_q} + POS_W'(5);
	assign in_body    = (pos_q != '0) && (pos_q <= body_end);
	assign in_payload = (pos_q >= POS_W'(5)) && (pos_q <= body_end);

	always_comb begin
		if ((crc_hi_q != crc_q[15:8]) || (data != crc_q[7:0])) begin
			kind = KIND_BAD_CRC;
		end else if (op_q != OPCODE_TAG_READ) begin
			kind = KIND_BAD_OP;
		end else if (len_q == '0) begin
			if (status_q == STATUS_KEEPALIVE) begin
				kind = KIND_KEEPALIVE;
			end else if (status_q == STATUS_THROTTLE) begin
				kind = KIND_THROTTLE;
			end else begin
				kind = KIND_UNKNOWN;
			end
		end else if (len_q == LEN_UNKNOWN_REC) begin
			kind = KIND_UNKNOWN;
		end else begin
			kind = KIND_TAG;
		end
	end

	assign tag  = (kind == KIND_TAG);
	assign fire = (pos_q != '0) && !in_body && (pos_q != crc_hi_pos);

	assign res.frame_kind      = kind;
	assign res.frame_opcode    = op_q;
	assign res.frame_status    = status_q;
	assign res.data_length     = len_q;
	assign res.signal_strength = tag ? rssi_q : '0;
	assign res.antenna_ports   = tag ? ant_q : '0;
	assign res.frequency_khz   = tag ? freq_q : '0;
	assign res.timestamp_ms    = tag ? ts_q : '0;

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		op_d     = op_q;
		status_d = status_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		rssi_d   = rssi_q;
		ant_d    = ant_q;
		freq_d   = freq_q;
		ts_d     = ts_q;
		if (pos_q == '0) begin
			if (data == HEADER_BYTE) begin
				pos_d    = POS_W'(1);
				len_d    = '0;
				op_d     = '0;
				status_d = '0;
				crc_d    = CRC_INIT;
				crc_hi_d = '0;
				rssi_d   = '0;
				ant_d    = '0;
				freq_d   = '0;
				ts_d     = '0;
			end
		end else if (in_body) begin
			crc_d = crc_upd;
			pos_d = pos_q + POS_W'(1);
			if (pos_q == POS_W'(1)) begin
				len_d = data;
			end else if (pos_q == POS_W'(2)) begin
				op_d = data;
			end else if (pos_q == POS_W'(3)) begin
				status_d = {data, status_q[7:0]};
			end else if (pos_q == POS_W'(4)) begin
				status_d = {status_q[15:8], data};
			end
			if (in_payload) begin
				if (pos_q == POS_W'(12)) begin
					rssi_d = data;
				end else if (pos_q == POS_W'(13)) begin
					ant_d = data;
				end else if ((pos_q >= POS_W'(14)) && (pos_q <= POS_W'(16))) begin
					freq_d = {freq_q[15:0], data};
				end else if ((pos_q >= POS_W'(17)) && (pos_q <= POS_W'(20))) begin
					ts_d = {ts_q[23:0], data};
				end
			end
		end else if (pos_q == crc_hi_pos) begin
			crc_hi_d = data;
			pos_d    = pos_q + POS_W'(1);
		end else begin
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			len_q    <= len_d;
			op_q     <= op_d;
			status_q <= status_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			rssi_q   <= rssi_d;
			ant_q    <= ant_d;
			freq_q   <= freq_d;
			ts_q     <= ts_d;
		end
	end

endmodule

// ----- sv/reader_response_frame_checker_unit.sv -----
// channel  | dir | beat contents
// s_axis   | in  | tdata[7:0] rx_byte
// m_axis   | out | tdata[111:0] one classification result per frame
//
// one byte per cycle sustained while no frame-ending byte waits for m_axis; a byte
// is held in the input register and its result, if any, is registered into the output
// register as it leaves; the frame state and crc update and the classification is made then
// bytes that end no frame keep flowing while a result waits on m_axis
// a frame-ending byte waits in the input register until m_axis is free
// arst_n clears the valids and returns the parser to header hunt
module reader_response_frame_checker_unit
	import rrfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,  // [7:0] rx_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [2:0] frame_kind, [10:3] frame_opcode, [26:11] frame_status,
	// [34:27] data_length, [42:35] signal_strength, [50:43] antenna_ports,
	// [74:51] frequency_khz, [106:75] timestamp_ms, [111:107] zero
	output logic [OUT_W-1:0]  m_axis_tdata
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic              fire;
	logic              out_free;
	logic              advance;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!fire || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	rrfc_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.fire   (fire),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && fire) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2};

endmodule

// ----- sv/rrfc_checker.sv -----
`include "reader_response_frame_checker_unit_assert.svh"

module rrfc_checker
	import rrfc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [BYTE_W-1:0] s_axis_tdata,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata
);

	logic [2:0]  kind;
	logic [7:0]  opcode;
	logic [15:0] status;
	logic [7:0]  length;
	logic        in_beat;

	assign kind    = m_axis_tdata[2:0];
	assign opcode  = m_axis_tdata[10:3];
	assign status  = m_axis_tdata[26:11];
	assign length  = m_axis_tdata[34:27];
	assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

	`RRFC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	`RRFC_ASSERT_IMPL(a_no_tag_fields, clk, arst_n, m_axis_tvalid && (kind != KIND_TAG), m_axis_tdata[111:35] == '0, "tag fields set on a non-tag result")

	`RRFC_ASSERT_IMPL(a_keepalive, clk, arst_n, m_axis_tvalid && (kind == KIND_KEEPALIVE), (length == '0) && (status == STATUS_KEEPALIVE) && (opcode == OPCODE_TAG_READ), "keepalive result with wrong header fields")

	`RRFC_ASSERT_IMPL(a_tag_found, clk, arst_n, m_axis_tvalid && (kind == KIND_TAG), (opcode == OPCODE_TAG_READ) && (length != '0) && (length != LEN_UNKNOWN_REC), "tag result with wrong header fields")

	`RRFC_ASSERT_NEXT(a_result_gap, clk, arst_n, in_beat && !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready), !m_axis_tvalid, "result without a preceding byte")

endmodule

bind reader_response_frame_checker_unit rrfc_checker u_rrfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
